### design/i2cmb_pkg.sv
// i2cmb_pkg: shared types and constants for the buffered I2C master.
// Used by i2cmb_core and i2c_master_buffered; no dependencies.
package i2cmb_pkg;

  localparam int unsigned BufDepthDflt  = 64;
  localparam logic [15:0] HalfPeriodRst = 16'd5;

  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_PUSH  = 3'd1;
  localparam logic [2:0] KIND_WRITE = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_POP   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ADDR_NAK = 2'd1;
  localparam logic [1:0] ST_DATA_NAK = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_HELD       = 5'd1,
    PH_PRE_A      = 5'd2,
    PH_PRE_B      = 5'd3,
    PH_START_A    = 5'd4,
    PH_START_B    = 5'd5,
    PH_TX_LOW     = 5'd6,
    PH_TX_HIGH    = 5'd7,
    PH_TXACK_LOW  = 5'd8,
    PH_TXACK_HIGH = 5'd9,
    PH_RX_LOW     = 5'd10,
    PH_RX_HIGH    = 5'd11,
    PH_RXACK_LOW  = 5'd12,
    PH_RXACK_HIGH = 5'd13,
    PH_STOP_0     = 5'd14,
    PH_STOP_A     = 5'd15,
    PH_STOP_B     = 5'd16,
    PH_HOLD_0     = 5'd17,
    PH_HOLD_A     = 5'd18
  } phase_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       accepted;
    logic [6:0] level;
  } result_t;

endpackage

### design/i2c_master_buffered.sv
// i2c_master_buffered: top level, three-entry result queue around i2cmb_core.
// Depends on i2cmb_pkg and i2cmb_core.
//
// Each request is one tick of the bus controller and is taken every cycle
// while the result queue has room; its result is registered, then queued.
// One result queue entry plus the result stage lets a new request enter while
// a result waits. SCL timing is half_period requests per half bit, stretched
// while the target holds SCL low. The byte buffer is a BUF_DEPTH x 8 memory
// with one write and one registered read port; entries never written read
// back undefined.
module i2c_master_buffered #(
  parameter int unsigned BUF_DEPTH = i2cmb_pkg::BufDepthDflt
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_byte_in,
  input  logic [6:0]  in_target_address,
  input  logic [6:0]  in_read_count,
  input  logic        in_send_stop,
  input  logic        in_scl_in,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_low,
  output logic        out_sda_low,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [1:0]  out_status,
  output logic [7:0]  out_byte_out,
  output logic        out_byte_valid,
  output logic        out_accepted,
  output logic [6:0]  out_level,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam logic [1:0] QDepth = 2'd3;

  logic               take, res_valid, pop;
  i2cmb_pkg::result_t res, head;
  i2cmb_pkg::result_t q_r [3];
  logic [1:0]         wp_r, rp_r, cnt_r;

  assign in_stall = ({1'b0, cnt_r} + {2'b0, res_valid}) >= {1'b0, QDepth};
  assign take     = in_valid && !in_stall;

  i2cmb_core #(.BUF_DEPTH(BUF_DEPTH)) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .kind           (in_kind),
    .byte_in        (in_byte_in),
    .target_address (in_target_address),
    .read_count     (in_read_count),
    .send_stop      (in_send_stop),
    .scl_in         (in_scl_in),
    .sda_in         (in_sda_in),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .res_valid      (res_valid),
    .res            (res)
  );

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign head      = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (res_valid) begin
      q_r[wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (res_valid) begin
        wp_r <= (wp_r == QDepth - 2'd1) ? 2'd0 : wp_r + 2'd1;
      end
      if (pop) begin
        rp_r <= (rp_r == QDepth - 2'd1) ? 2'd0 : rp_r + 2'd1;
      end
      cnt_r <= cnt_r + {1'b0, res_valid} - {1'b0, pop};
    end
  end

  assign out_scl_low    = head.scl_low;
  assign out_sda_low    = head.sda_low;
  assign out_busy_res   = head.busy_res;
  assign out_done_res   = head.done_res;
  assign out_status     = head.status;
  assign out_byte_out   = head.byte_out;
  assign out_byte_valid = head.byte_valid;
  assign out_accepted   = head.accepted;
  assign out_level      = head.level;

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QDepth)
    else $error("result queue overflow");
  a_no_take_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == QDepth) |-> !take)
    else $error("request taken with full queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !pop) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count lost a result");
`endif

endmodule

### design/i2cmb_core.sv
// i2cmb_core: bus sequencer, byte buffer and per-request result stage.
// Depends on i2cmb_pkg.
module i2cmb_core #(
  parameter int unsigned BUF_DEPTH = i2cmb_pkg::BufDepthDflt
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [2:0]        kind,
  input  logic [7:0]        byte_in,
  input  logic [6:0]        target_address,
  input  logic [6:0]        read_count,
  input  logic              send_stop,
  input  logic              scl_in,
  input  logic              sda_in,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  output logic              res_valid,
  output i2cmb_pkg::result_t res
);

  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [CW-1:0] DepthC = CW'(BUF_DEPTH);

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] mem_q;
  logic       mem_re, mem_we;
  logic [AW-1:0] mem_ra, mem_wa;
  logic [7:0] mem_wd;

  i2cmb_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0] fill_r, fill_nxt, rp_r, rp_nxt, bytec_r, bytec_nxt;
  logic [15:0]   tick_r, tick_nxt, hp_r;
  logic [3:0]    bit_r, bit_nxt;
  logic [7:0]    shift_r, shift_nxt, sh;
  logic          shsel_r, shsel_nxt;
  logic          rd_r, rd_nxt, stop_r, stop_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [6:0]    addr_r, addr_nxt;
  logic          pv_r, done_r, done_nxt, valid_r, valid_nxt, acc_r, acc_nxt;

  logic          ready, go, do_load, end_seq, rx_last;
  logic [16:0]   tick_inc;
  logic [15:0]   hp;
  logic [CW-1:0] ld_ptr;
  logic [CW:0]   bytec_inc;

  assign hp      = (hp_r == 16'd0) ? 16'd1 : hp_r;
  assign sh      = shsel_r ? mem_q : shift_r;
  assign rx_last = ({1'b0, bytec_r} + 1'b1) >= {1'b0, fill_r};

  always_comb begin
    phase_nxt  = phase_r;
    fill_nxt   = fill_r;
    rp_nxt     = rp_r;
    bytec_nxt  = bytec_r;
    tick_nxt   = tick_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    shsel_nxt  = shsel_r;
    rd_nxt     = rd_r;
    stop_nxt   = stop_r;
    status_nxt = status_r;
    addr_nxt   = addr_r;
    done_nxt   = 1'b0;
    valid_nxt  = 1'b0;
    acc_nxt    = 1'b0;
    mem_re     = 1'b0;
    mem_ra     = rp_r[AW-1:0];
    mem_we     = 1'b0;
    mem_wa     = fill_r[AW-1:0];
    mem_wd     = byte_in;
    ready      = 1'b1;
    go         = 1'b1;
    do_load    = 1'b0;
    end_seq    = 1'b0;
    ld_ptr     = rp_r;
    tick_inc   = {1'b0, tick_r} + 17'd1;
    bytec_inc  = {1'b0, bytec_r} + 1'b1;
    if (take) begin
      shift_nxt = sh;
      shsel_nxt = 1'b0;
      if (phase_r == i2cmb_pkg::PH_IDLE || phase_r == i2cmb_pkg::PH_HELD) begin
        case (kind)
          i2cmb_pkg::KIND_PUSH: begin
            if (fill_r < DepthC) begin
              mem_we   = 1'b1;
              fill_nxt = fill_r + 1'b1;
              acc_nxt  = 1'b1;
            end
          end
          i2cmb_pkg::KIND_POP: begin
            if (rp_r < fill_r) begin
              mem_re    = 1'b1;
              rp_nxt    = rp_r + 1'b1;
              valid_nxt = 1'b1;
            end
          end
          i2cmb_pkg::KIND_WRITE, i2cmb_pkg::KIND_READ: begin
            addr_nxt   = target_address;
            stop_nxt   = send_stop;
            rd_nxt     = (kind == i2cmb_pkg::KIND_READ);
            status_nxt = i2cmb_pkg::ST_OK;
            tick_nxt   = '0;
            bit_nxt    = '0;
            bytec_nxt  = '0;
            rp_nxt     = '0;
            if (kind == i2cmb_pkg::KIND_READ) begin
              fill_nxt  = (32'(read_count) < BUF_DEPTH) ? CW'(read_count) : DepthC;
              phase_nxt = i2cmb_pkg::PH_START_A;
            end else begin
              phase_nxt = i2cmb_pkg::PH_PRE_A;
            end
          end
          default: ;
        endcase
      end else begin
        if (tick_r == 16'd0) begin
          case (phase_r)
            i2cmb_pkg::PH_PRE_A, i2cmb_pkg::PH_STOP_A, i2cmb_pkg::PH_TX_HIGH,
            i2cmb_pkg::PH_TXACK_HIGH, i2cmb_pkg::PH_RX_HIGH,
            i2cmb_pkg::PH_RXACK_HIGH, i2cmb_pkg::PH_HOLD_A: ready = scl_in;
            i2cmb_pkg::PH_PRE_B, i2cmb_pkg::PH_STOP_B,
            i2cmb_pkg::PH_HOLD_0:                           ready = sda_in;
            i2cmb_pkg::PH_TX_LOW:    ready = sh[7] ? sda_in : 1'b1;
            i2cmb_pkg::PH_RXACK_LOW: ready = rx_last ? sda_in : 1'b1;
            default:                 ready = 1'b1;
          endcase
          if (ready) begin
            if (phase_r == i2cmb_pkg::PH_TXACK_HIGH) begin
              shift_nxt = {7'd0, sda_in};
            end else if (phase_r == i2cmb_pkg::PH_RX_HIGH) begin
              shift_nxt = {sh[6:0], sda_in};
            end
          end else begin
            go = 1'b0;
          end
        end
        if (go) begin
          if (tick_inc >= {1'b0, hp}) begin
            tick_nxt = '0;
            case (phase_r)
              i2cmb_pkg::PH_PRE_A:   phase_nxt = i2cmb_pkg::PH_PRE_B;
              i2cmb_pkg::PH_PRE_B:   phase_nxt = i2cmb_pkg::PH_START_A;
              i2cmb_pkg::PH_START_A: phase_nxt = i2cmb_pkg::PH_START_B;
              i2cmb_pkg::PH_START_B: begin
                shift_nxt = {addr_r, rd_r};
                bit_nxt   = '0;
                bytec_nxt = '0;
                phase_nxt = i2cmb_pkg::PH_TX_LOW;
              end
              i2cmb_pkg::PH_TX_LOW: phase_nxt = i2cmb_pkg::PH_TX_HIGH;
              i2cmb_pkg::PH_TX_HIGH: begin
                shift_nxt = {shift_nxt[6:0], 1'b0};
                bit_nxt   = bit_r + 4'd1;
                phase_nxt = (bit_nxt >= 4'd8) ? i2cmb_pkg::PH_TXACK_LOW
                                              : i2cmb_pkg::PH_TX_LOW;
              end
              i2cmb_pkg::PH_TXACK_LOW: phase_nxt = i2cmb_pkg::PH_TXACK_HIGH;
              i2cmb_pkg::PH_TXACK_HIGH: begin
                if (bytec_r == '0) begin
                  if (shift_nxt[0]) begin
                    status_nxt = i2cmb_pkg::ST_ADDR_NAK;
                    if (rd_r) begin
                      fill_nxt = '0;
                      rp_nxt   = '0;
                    end
                    end_seq = 1'b1;
                  end else if (rd_r) begin
                    if (fill_r == '0) begin
                      end_seq = 1'b1;
                    end else begin
                      shift_nxt = '0;
                      bit_nxt   = '0;
                      phase_nxt = i2cmb_pkg::PH_RX_LOW;
                    end
                  end else begin
                    bytec_nxt = CW'(1);
                    do_load   = 1'b1;
                    ld_ptr    = rp_r;
                  end
                end else if (shift_nxt[0]) begin
                  status_nxt = i2cmb_pkg::ST_DATA_NAK;
                  end_seq    = 1'b1;
                end else begin
                  ld_ptr  = rp_r + 1'b1;
                  rp_nxt  = ld_ptr;
                  do_load = 1'b1;
                end
                if (do_load) begin
                  if (ld_ptr < fill_r) begin
                    // next byte comes out of the buffer on the next clock
                    mem_re    = 1'b1;
                    mem_ra    = ld_ptr[AW-1:0];
                    shsel_nxt = 1'b1;
                    bit_nxt   = '0;
                    phase_nxt = i2cmb_pkg::PH_TX_LOW;
                  end else begin
                    end_seq = 1'b1;
                  end
                end
              end
              i2cmb_pkg::PH_RX_LOW: phase_nxt = i2cmb_pkg::PH_RX_HIGH;
              i2cmb_pkg::PH_RX_HIGH: begin
                bit_nxt = bit_r + 4'd1;
                if (bit_nxt >= 4'd8) begin
                  mem_we    = 1'b1;
                  mem_wa    = bytec_r[AW-1:0];
                  mem_wd    = shift_nxt;
                  phase_nxt = i2cmb_pkg::PH_RXACK_LOW;
                end else begin
                  phase_nxt = i2cmb_pkg::PH_RX_LOW;
                end
              end
              i2cmb_pkg::PH_RXACK_LOW: phase_nxt = i2cmb_pkg::PH_RXACK_HIGH;
              i2cmb_pkg::PH_RXACK_HIGH: begin
                bytec_nxt = bytec_inc[CW-1:0];
                if (bytec_inc >= {1'b0, fill_r}) begin
                  end_seq = 1'b1;
                end else begin
                  shift_nxt = '0;
                  bit_nxt   = '0;
                  phase_nxt = i2cmb_pkg::PH_RX_LOW;
                end
              end
              i2cmb_pkg::PH_STOP_0: phase_nxt = i2cmb_pkg::PH_STOP_A;
              i2cmb_pkg::PH_STOP_A: phase_nxt = i2cmb_pkg::PH_STOP_B;
              i2cmb_pkg::PH_HOLD_0: phase_nxt = i2cmb_pkg::PH_HOLD_A;
              i2cmb_pkg::PH_STOP_B, i2cmb_pkg::PH_HOLD_A: begin
                phase_nxt = (phase_r == i2cmb_pkg::PH_STOP_B) ? i2cmb_pkg::PH_IDLE
                                                              : i2cmb_pkg::PH_HELD;
                done_nxt  = 1'b1;
                if (!rd_r) begin
                  fill_nxt = '0;
                  rp_nxt   = '0;
                end
              end
              default: phase_nxt = i2cmb_pkg::PH_IDLE;
            endcase
            if (end_seq) begin
              phase_nxt = stop_r ? i2cmb_pkg::PH_STOP_0 : i2cmb_pkg::PH_HOLD_0;
            end
          end else begin
            tick_nxt = tick_inc[15:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= i2cmb_pkg::PH_IDLE;
      fill_r   <= '0;
      rp_r     <= '0;
      bytec_r  <= '0;
      tick_r   <= '0;
      bit_r    <= '0;
      shift_r  <= '0;
      shsel_r  <= 1'b0;
      rd_r     <= 1'b0;
      stop_r   <= 1'b0;
      status_r <= i2cmb_pkg::ST_OK;
      addr_r   <= '0;
      hp_r     <= i2cmb_pkg::HalfPeriodRst;
      pv_r     <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      fill_r   <= fill_nxt;
      rp_r     <= rp_nxt;
      bytec_r  <= bytec_nxt;
      tick_r   <= tick_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      shsel_r  <= shsel_nxt;
      rd_r     <= rd_nxt;
      stop_r   <= stop_nxt;
      status_r <= status_nxt;
      addr_r   <= addr_nxt;
      pv_r     <= take;
      if (cfg_wr_en) begin
        hp_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      done_r  <= done_nxt;
      valid_r <= valid_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Result of the last request, built from the state it left behind.
  always_comb begin
    res            = '0;
    res.busy_res   = (phase_r != i2cmb_pkg::PH_IDLE) && (phase_r != i2cmb_pkg::PH_HELD);
    res.done_res   = done_r;
    res.status     = status_r;
    res.byte_out   = valid_r ? mem_q : 8'd0;
    res.byte_valid = valid_r;
    res.accepted   = acc_r;
    res.level      = 7'(fill_r - rp_r);
    case (phase_r)
      i2cmb_pkg::PH_HELD, i2cmb_pkg::PH_PRE_A, i2cmb_pkg::PH_START_A,
      i2cmb_pkg::PH_STOP_A: res.sda_low = 1'b1;
      i2cmb_pkg::PH_START_B, i2cmb_pkg::PH_STOP_0: begin
        res.scl_low = 1'b1;
        res.sda_low = 1'b1;
      end
      i2cmb_pkg::PH_TX_LOW: begin
        res.scl_low = 1'b1;
        res.sda_low = !sh[7];
      end
      i2cmb_pkg::PH_TX_HIGH: res.sda_low = !sh[7];
      i2cmb_pkg::PH_TXACK_LOW, i2cmb_pkg::PH_RX_LOW,
      i2cmb_pkg::PH_HOLD_0: res.scl_low = 1'b1;
      i2cmb_pkg::PH_RXACK_LOW: begin
        res.scl_low = 1'b1;
        res.sda_low = !rx_last;
      end
      i2cmb_pkg::PH_RXACK_HIGH: res.sda_low = !rx_last;
      default: ;
    endcase
  end

  assign res_valid = pv_r;

`ifndef SYNTHESIS
  a_shsel_tx: assert property (@(posedge clk) disable iff (!rst_n)
    shsel_r |-> (phase_r == i2cmb_pkg::PH_TX_LOW || phase_r == i2cmb_pkg::PH_TX_HIGH))
    else $error("buffer byte pending outside transmit");
  a_rp_fill: assert property (@(posedge clk) disable iff (!rst_n)
    rp_r <= fill_r && fill_r <= DepthC)
    else $error("buffer pointers out of order");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pv_r && done_r) |-> !res.busy_res)
    else $error("done while busy");
`endif

endmodule

### tb/i2c_master_buffered_tb.sv
// i2c_master_buffered_tb: self-checking bench for the buffered I2C master.
// Needs i2cmb_pkg and i2c_master_buffered; the bus predictor lives in here.
`timescale 1ns / 100ps

module i2c_master_buffered_tb;
  import i2cmb_pkg::*;

  localparam int DEPTH = 64;
  localparam int WDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_in;
    logic [6:0] addr;
    logic [6:0] rcount;
    logic       stop;
    logic       scl;
    logic       sda;
  } req_t;

  typedef struct {
    req_t    r;
    bit      typed;
    result_t e;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_kind = KIND_TICK;
  logic [7:0] in_byte_in = '0;
  logic [6:0] in_target_address = '0;
  logic [6:0] in_read_count = '0;
  logic in_send_stop = 1'b0;
  logic in_scl_in = 1'b1;
  logic in_sda_in = 1'b1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_scl_low, out_sda_low, out_busy_res, out_done_res;
  logic [1:0] out_status;
  logic [7:0] out_byte_out;
  logic out_byte_valid, out_accepted;
  logic [6:0] out_level;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  i2c_master_buffered DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_byte_in(in_byte_in),
    .in_target_address(in_target_address), .in_read_count(in_read_count),
    .in_send_stop(in_send_stop), .in_scl_in(in_scl_in), .in_sda_in(in_sda_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_scl_low(out_scl_low), .out_sda_low(out_sda_low),
    .out_busy_res(out_busy_res), .out_done_res(out_done_res),
    .out_status(out_status), .out_byte_out(out_byte_out),
    .out_byte_valid(out_byte_valid), .out_accepted(out_accepted),
    .out_level(out_level),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------- bus controller predictor ----------------
  logic [15:0] half_q = HalfPeriodRst;
  logic [7:0] bytes_q [DEPTH];
  int unsigned fill_q, rptr_q, ticks_q, bits_q, shreg_q, nbytes_q;
  logic [3:0] flags_q;
  logic [6:0] addr_q;
  phase_t ph_q = PH_IDLE;
  bit done_q;

  result_t expected_q[$];
  int errors = 0;
  int n_items = 0, n_txns = 0, n_results = 0;

  function automatic bit last_rx();
    return nbytes_q + 1 >= fill_q;
  endfunction

  function automatic void to_end();
    ph_q = flags_q[1] ? PH_STOP_0 : PH_HOLD_0;
  endfunction

  function automatic void set_status(logic [1:0] s);
    flags_q[3:2] = s;
  endfunction

  function automatic void wrap_up(phase_t nxt);
    ph_q = nxt;
    done_q = 1'b1;
    if (!flags_q[0]) begin
      fill_q = 0;
      rptr_q = 0;
    end
  endfunction

  function automatic bit lines_ok(logic scl, logic sda);
    case (ph_q)
      PH_PRE_A, PH_STOP_A, PH_TX_HIGH, PH_TXACK_HIGH, PH_RX_HIGH, PH_RXACK_HIGH,
      PH_HOLD_A: return scl;
      PH_PRE_B, PH_STOP_B, PH_HOLD_0: return sda;
      PH_TX_LOW: return shreg_q[7] ? sda : 1'b1;
      PH_RXACK_LOW: return last_rx() ? sda : 1'b1;
      default: return 1'b1;
    endcase
  endfunction

  function automatic void next_phase();
    bit more;
    more = 1'b1;
    case (ph_q)
      PH_PRE_A: ph_q = PH_PRE_B;
      PH_PRE_B: ph_q = PH_START_A;
      PH_START_A: ph_q = PH_START_B;
      PH_START_B: begin
        shreg_q = {addr_q, flags_q[0]};
        bits_q = 0;
        nbytes_q = 0;
        ph_q = PH_TX_LOW;
      end
      PH_TX_LOW: ph_q = PH_TX_HIGH;
      PH_TX_HIGH: begin
        shreg_q = (shreg_q << 1) & 8'hFE;
        bits_q++;
        ph_q = (bits_q >= 8) ? PH_TXACK_LOW : PH_TX_LOW;
      end
      PH_TXACK_LOW: ph_q = PH_TXACK_HIGH;
      PH_TXACK_HIGH: begin
        if (nbytes_q == 0) begin
          if (shreg_q[0]) begin
            set_status(ST_ADDR_NAK);
            if (flags_q[0]) begin
              fill_q = 0;
              rptr_q = 0;
            end
            to_end();
            more = 1'b0;
          end else begin
            nbytes_q = 1;
            if (flags_q[0]) begin
              nbytes_q = 0;
              if (fill_q == 0) begin
                to_end();
              end else begin
                shreg_q = 0;
                bits_q = 0;
                ph_q = PH_RX_LOW;
              end
              more = 1'b0;
            end
          end
        end else if (shreg_q[0]) begin
          set_status(ST_DATA_NAK);
          to_end();
          more = 1'b0;
        end else begin
          rptr_q++;
        end
        if (more) begin
          if (rptr_q < fill_q && rptr_q < DEPTH) begin
            shreg_q = bytes_q[rptr_q];
            bits_q = 0;
            ph_q = PH_TX_LOW;
          end else begin
            to_end();
          end
        end
      end
      PH_RX_LOW: ph_q = PH_RX_HIGH;
      PH_RX_HIGH: begin
        bits_q++;
        if (bits_q >= 8) begin
          if (nbytes_q < DEPTH) bytes_q[nbytes_q] = shreg_q[7:0];
          ph_q = PH_RXACK_LOW;
        end else begin
          ph_q = PH_RX_LOW;
        end
      end
      PH_RXACK_LOW: ph_q = PH_RXACK_HIGH;
      PH_RXACK_HIGH: begin
        nbytes_q++;
        if (nbytes_q >= fill_q) begin
          to_end();
        end else begin
          shreg_q = 0;
          bits_q = 0;
          ph_q = PH_RX_LOW;
        end
      end
      PH_STOP_0: ph_q = PH_STOP_A;
      PH_STOP_A: ph_q = PH_STOP_B;
      PH_STOP_B: wrap_up(PH_IDLE);
      PH_HOLD_0: ph_q = PH_HOLD_A;
      PH_HOLD_A: wrap_up(PH_HELD);
      default: ph_q = PH_IDLE;
    endcase
  endfunction

  function automatic bit bus_busy();
    return ph_q != PH_IDLE && ph_q != PH_HELD;
  endfunction

  function automatic result_t bus_tick(req_t r);
    result_t res;
    int unsigned hp;
    hp = (half_q == 0) ? 1 : half_q;
    res = '0;
    done_q = 1'b0;
    if (!bus_busy()) begin
      if (r.kind == KIND_PUSH) begin
        if (fill_q < DEPTH) begin
          bytes_q[fill_q] = r.byte_in;
          fill_q++;
          res.accepted = 1'b1;
        end
      end else if (r.kind == KIND_POP) begin
        if (rptr_q < fill_q && rptr_q < DEPTH) begin
          res.byte_out = bytes_q[rptr_q];
          rptr_q++;
          res.byte_valid = 1'b1;
        end
      end else if (r.kind == KIND_WRITE || r.kind == KIND_READ) begin
        addr_q = r.addr;
        flags_q = {2'b00, r.stop, r.kind == KIND_READ};
        ticks_q = 0;
        bits_q = 0;
        nbytes_q = 0;
        rptr_q = 0;
        if (r.kind == KIND_READ) begin
          fill_q = (r.rcount < DEPTH) ? r.rcount : DEPTH;
          ph_q = PH_START_A;
        end else begin
          ph_q = PH_PRE_A;
        end
      end
    end else if (ticks_q != 0 || lines_ok(r.scl, r.sda)) begin
      if (ticks_q == 0) begin
        if (ph_q == PH_TXACK_HIGH) shreg_q = r.sda;
        else if (ph_q == PH_RX_HIGH) shreg_q = ((shreg_q << 1) | r.sda) & 8'hFF;
      end
      ticks_q++;
      if (ticks_q >= hp) begin
        ticks_q = 0;
        next_phase();
      end
    end
    case (ph_q)
      PH_HELD, PH_PRE_A, PH_START_A, PH_STOP_A: res.sda_low = 1'b1;
      PH_START_B, PH_STOP_0: begin
        res.scl_low = 1'b1;
        res.sda_low = 1'b1;
      end
      PH_TX_LOW: begin
        res.scl_low = 1'b1;
        res.sda_low = !shreg_q[7];
      end
      PH_TX_HIGH: res.sda_low = !shreg_q[7];
      PH_TXACK_LOW, PH_RX_LOW, PH_HOLD_0: res.scl_low = 1'b1;
      PH_RXACK_LOW: begin
        res.scl_low = 1'b1;
        res.sda_low = !last_rx();
      end
      PH_RXACK_HIGH: res.sda_low = !last_rx();
      default: ;
    endcase
    res.busy_res = bus_busy();
    res.done_res = done_q;
    res.status = flags_q[3:2];
    res.level = (fill_q >= rptr_q) ? 7'(fill_q - rptr_q) : 7'd0;
    return res;
  endfunction

  // ---------------- request side ----------------
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  int sda_pct = 10;

  task automatic send(req_t r, bit typed = 1'b0, result_t t = '0);
    result_t p;
    int g;
    if (gaps_on && $urandom_range(0, 99) < 10) begin
      g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= r.kind;
    in_byte_in <= r.byte_in;
    in_target_address <= r.addr;
    in_read_count <= r.rcount;
    in_send_stop <= r.stop;
    in_scl_in <= r.scl;
    in_sda_in <= r.sda;
    do @(posedge clk); while (in_stall);
    p = bus_tick(r);
    expected_q.push_back(typed ? t : p);
    n_items++;
  endtask

  function automatic req_t rand_req(logic [2:0] k);
    req_t r;
    r.kind = k;
    r.byte_in = $urandom_range(0, 255);
    r.addr = $urandom_range(0, 127);
    r.rcount = $urandom_range(0, 127);
    r.stop = $urandom_range(0, 1);
    r.scl = $urandom_range(0, 9) != 0;
    r.sda = $urandom_range(0, 99) < sda_pct;
    return r;
  endfunction

  // Start a transfer and clock the bus until it ends; the odd command
  // thrown in while busy must be ignored.
  task automatic run_xfer(logic [2:0] k, logic [6:0] a, logic [6:0] n, logic s, int pct);
    req_t r;
    sda_pct = pct;
    r = rand_req(k);
    r.addr = a;
    r.rcount = n;
    r.stop = s;
    send(r);
    n_txns++;
    while (bus_busy()) begin
      send(rand_req($urandom_range(0, 9) == 0 ? 3'($urandom_range(0, 7)) : KIND_TICK));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_half(logic [15:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    half_q = v;
  endtask

  function automatic logic [6:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return $urandom_range(0, 4);
    if (r == 8) return $urandom_range(5, 70);
    return $urandom_range(71, 127);
  endfunction

  task automatic random_phase(int budget, bit xfers);
    int stop_at, a, i, n;
    req_t r;
    stop_at = n_items + budget;
    while (n_items < stop_at) begin
      a = $urandom_range(0, 99);
      if (a < 35) begin
        n = ($urandom_range(0, 9) == 0) ? 70 : $urandom_range(1, 6);
        for (i = 0; i < n; i++) send(rand_req(KIND_PUSH));
      end else if (a < 55) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) send(rand_req(KIND_POP));
      end else if (a < 85 && xfers) begin
        case ($urandom_range(0, 3))
          0: sda_pct = 90;
          1: sda_pct = 50;
          default: sda_pct = 10;
        endcase
        run_xfer($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, $urandom_range(0, 127),
                 pick_count(), $urandom_range(0, 1), sda_pct);
      end else begin
        r = rand_req($urandom_range(0, 1) ? KIND_TICK : 3'($urandom_range(5, 7)));
        send(r);
      end
    end
  endtask

  function automatic result_t idle_res(logic [6:0] lvl, logic acc, logic vld, logic [7:0] b);
    result_t t;
    t = '0;
    t.level = lvl;
    t.accepted = acc;
    t.byte_valid = vld;
    t.byte_out = b;
    return t;
  endfunction

  function automatic req_t mk_req(logic [2:0] k, logic [7:0] b);
    req_t r;
    r = '0;
    r.kind = k;
    r.byte_in = b;
    r.scl = 1'b1;
    r.sda = 1'b1;
    return r;
  endfunction

  row_t dir_tab[10];

  initial begin
    int i;
    dir_tab[0] = '{mk_req(KIND_POP, 8'h00), 1'b1, idle_res(0, 0, 0, 8'h00)};
    dir_tab[1] = '{mk_req(3'd5, 8'hFF), 1'b1, idle_res(0, 0, 0, 8'h00)};
    dir_tab[2] = '{mk_req(3'd7, 8'hFF), 1'b1, idle_res(0, 0, 0, 8'h00)};
    dir_tab[3] = '{mk_req(3'd6, 8'h00), 1'b1, idle_res(0, 0, 0, 8'h00)};
    dir_tab[4] = '{mk_req(KIND_PUSH, 8'hFF), 1'b1, idle_res(1, 1, 0, 8'h00)};
    dir_tab[5] = '{mk_req(KIND_PUSH, 8'h00), 1'b1, idle_res(2, 1, 0, 8'h00)};
    dir_tab[6] = '{mk_req(KIND_POP, 8'h00), 1'b1, idle_res(1, 0, 1, 8'hFF)};
    dir_tab[7] = '{mk_req(KIND_PUSH, 8'hA5), 1'b0, '0};
    dir_tab[8] = '{'{KIND_TICK, 8'hFF, 7'h7F, 7'h7F, 1'b1, 1'b0, 1'b0}, 1'b0, '0};
    dir_tab[9] = '{mk_req(KIND_POP, 8'h00), 1'b1, idle_res(1, 0, 1, 8'h00)};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 10; i++) send(dir_tab[i].r, dir_tab[i].typed, dir_tab[i].e);

    // directed transfers at the reset half period
    run_xfer(KIND_WRITE, 7'h7F, 7'd0, 1'b1, 10);
    run_xfer(KIND_READ, 7'h00, 7'd0, 1'b1, 10);
    run_xfer(KIND_READ, 7'h55, 7'h7F, 1'b0, 10);   // saturates, ends held
    for (i = 0; i < 65; i++) send(rand_req(KIND_POP));
    run_xfer(KIND_WRITE, 7'h2A, 7'd0, 1'b0, 10);   // repeated start from held bus
    run_xfer(KIND_READ, 7'h12, 7'd3, 1'b1, 100);   // address never acked
    for (i = 0; i < 65; i++) send(rand_req(KIND_PUSH));  // last one bounces
    run_xfer(KIND_WRITE, 7'h33, 7'd0, 1'b1, 50);

    set_half(16'd0);
    random_phase(300, 1'b1);
    set_half(16'd1);
    hold_req = 1'b1;
    random_phase(400, 1'b1);
    set_half(16'd65535);
    gaps_on = 1'b0;
    random_phase(60, 1'b0);
    gaps_on = 1'b1;
    set_half(16'd2);
    random_phase(250, 1'b1);
    set_half(16'd3);
    random_phase(200, 1'b1);

    drain();
    $display("Run summary: %0d requests, %0d bus transfers, %0d results checked",
             n_items, n_txns, n_results);
    $display("Half periods 0, 1, 2, 3, 5 and 65535; reads, writes, NACKs, held bus.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------- result side ----------------
  int hold_cnt = 0;

  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      r = $urandom_range(0, 199);
      if (r < 2) hold_cnt = $urandom_range(5, 30);
      out_stall <= (r < 40);
    end
  end

  function automatic void cmp(string name, int e, int a);
    if (e != a) begin
      errors++;
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
    end
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result with no request outstanding");
      end else begin
        e = expected_q.pop_front();
        cmp("scl_low", e.scl_low, out_scl_low);
        cmp("sda_low", e.sda_low, out_sda_low);
        cmp("busy_res", e.busy_res, out_busy_res);
        cmp("done_res", e.done_res, out_done_res);
        cmp("status", e.status, out_status);
        cmp("byte_out", e.byte_out, out_byte_out);
        cmp("byte_valid", e.byte_valid, out_byte_valid);
        cmp("accepted", e.accepted, out_accepted);
        cmp("level", e.level, out_level);
      end
    end
  end

  int quiet = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

### i2c_master_buffered.f
design/i2cmb_pkg.sv
design/i2cmb_core.sv
design/i2c_master_buffered.sv
tb/i2c_master_buffered_tb.sv
